/* rtl/shsf_pkg.sv */
// Package for the streaming SuperFastHash core: mixing functions and constants.
`default_nettype none
package shsf_pkg;

    localparam int unsigned WordW   = 32;
    localparam int unsigned TailW   = 2;
    localparam logic [WordW-1:0] CountMax = 32'hFFFF_FFFF;

    typedef logic [WordW-1:0] word_t;
    typedef logic [TailW-1:0] tail_t;

    typedef enum logic [TailW-1:0] {
        TAIL_NONE  = 2'd0,
        TAIL_ONE   = 2'd1,
        TAIL_TWO   = 2'd2,
        TAIL_THREE = 2'd3
    } tail_code_t;

    // Saturating add for the byte counter.
    function automatic word_t sat_add(input word_t a, input word_t b);
        logic [WordW:0] s;
        begin
            s = {1'b0, a} + {1'b0, b};
            sat_add = s[WordW] ? CountMax : s[WordW-1:0];
        end
    endfunction

    // One round on a full 4-byte group.
    function automatic word_t mix_group(input word_t h, input word_t w);
        word_t hs;
        word_t t;
        word_t hx;
        begin
            hs = h + {16'd0, w[15:0]};
            t  = {5'd0, w[31:16], 11'd0} ^ hs;
            hx = {hs[15:0], 16'd0} ^ t;
            mix_group = hx + (hx >> 11);
        end
    endfunction

    // End-case mixing of 0 to 3 tail bytes.
    function automatic word_t mix_tail(input word_t h, input word_t w, input tail_t n);
        word_t hs;
        word_t hx;
        begin
            hs = '0;
            hx = '0;
            unique case (tail_code_t'(n))
                TAIL_THREE:
                begin
                    hs = h + {16'd0, w[15:0]};
                    hx = hs ^ {hs[15:0], 16'd0} ^ {6'd0, w[23:16], 18'd0};
                    mix_tail = hx + (hx >> 11);
                end
                TAIL_TWO:
                begin
                    hs = h + {16'd0, w[15:0]};
                    hx = hs ^ (hs << 11);
                    mix_tail = hx + (hx >> 17);
                end
                TAIL_ONE:
                begin
                    hs = h + {24'd0, w[7:0]};
                    hx = hs ^ (hs << 10);
                    mix_tail = hx + (hx >> 1);
                end
                default:
                begin
                    mix_tail = h;
                end
            endcase
        end
    endfunction

    // First half of the avalanche: xor, add, xor.
    function automatic word_t aval_front(input word_t h);
        word_t a;
        word_t b;
        begin
            a = h ^ (h << 3);
            b = a + (a >> 5);
            aval_front = b ^ (b << 4);
        end
    endfunction

    // Second half of the avalanche: add, xor, add.
    function automatic word_t aval_back(input word_t h);
        word_t a;
        word_t b;
        begin
            a = h + (h >> 17);
            b = a ^ (a << 25);
            aval_back = b + (b >> 6);
        end
    endfunction

endpackage
`default_nettype wire

/* rtl/string_hash_superfast_core.sv */
// Streaming SuperFastHash core (seed zero): input register, mix, two avalanche stages.
//
// Input channel: word / tail_bytes / last with in_valid and in_stall. Each beat
// without last carries four string bytes (first byte in bits 7:0) and runs one
// mixing round. The beat with last carries 0 to 3 tail bytes in the low bits
// of word, counted by tail_bytes; the upper bytes are ignored.
// Output channel: hash_value / byte_length with out_valid and out_stall. One
// result per string, issued for the last beat only.
// Throughput: one input beat per cycle while in_stall is low, set by the single
// add/shift/xor round on the running hash. The last beat passes from the input
// register to the mix stage, then through two avalanche stages, to out_valid.
// Reset clears the running hash, byte count and all stage valids; a new string
// can start right after reset. When out_stall is high the result holds; the
// bubbles ahead of the output still fill, then in_stall rises.
// byte_length saturates at all ones.
`default_nettype none
module string_hash_superfast_core
    import shsf_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic [WordW-1:0]   word,
    input  wire logic [TailW-1:0]   tail_bytes,
    input  wire logic               last,
    input  wire logic               in_valid,
    output logic                    in_stall,
    output logic [WordW-1:0]        hash_value,
    output logic [WordW-1:0]        byte_length,
    output logic                    out_valid,
    input  wire logic               out_stall
);

    word_t a_word_reg;
    tail_t a_tail_reg;
    logic  a_last_reg;
    logic  a_valid_reg;

    word_t run_hash_reg, run_hash_next;
    word_t byte_cnt_reg, byte_cnt_next;

    word_t b_hash_reg;
    word_t b_len_reg;
    logic  b_valid_reg;

    word_t c_hash_reg;
    word_t c_len_reg;
    logic  c_valid_reg;

    word_t d_hash_reg;
    word_t d_len_reg;
    logic  d_valid_reg;

    logic d_ready, c_ready, b_ready, a_ready;
    logic a_move, a_done;
    word_t tail_hash;
    word_t tail_len;

    assign d_ready = !d_valid_reg || !out_stall;
    assign c_ready = !c_valid_reg || d_ready;
    assign b_ready = !b_valid_reg || c_ready;
    assign a_ready = !a_valid_reg || b_ready;
    assign in_stall = !a_ready;

    assign a_move = a_valid_reg && b_ready;
    assign a_done = a_move && a_last_reg;

    assign tail_hash = mix_tail(run_hash_reg, a_word_reg, a_tail_reg);
    assign tail_len  = sat_add(byte_cnt_reg, {{(WordW-TailW){1'b0}}, a_tail_reg});

    always_comb
    begin
        run_hash_next = run_hash_reg;
        byte_cnt_next = byte_cnt_reg;
        if (a_move)
        begin
            if (a_last_reg)
            begin
                run_hash_next = '0;
                byte_cnt_next = '0;
            end
            else
            begin
                run_hash_next = mix_group(run_hash_reg, a_word_reg);
                byte_cnt_next = sat_add(byte_cnt_reg, WordW'(4));
            end
        end
    end

    // control and running state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg  <= 1'b0;
            b_valid_reg  <= 1'b0;
            c_valid_reg  <= 1'b0;
            d_valid_reg  <= 1'b0;
            run_hash_reg <= '0;
            byte_cnt_reg <= '0;
        end
        else
        begin
            run_hash_reg <= run_hash_next;
            byte_cnt_reg <= byte_cnt_next;
            if (a_ready)
            begin
                a_valid_reg <= in_valid;
            end
            if (b_ready)
            begin
                b_valid_reg <= a_done;
            end
            if (c_ready)
            begin
                c_valid_reg <= b_valid_reg;
            end
            if (d_ready)
            begin
                d_valid_reg <= c_valid_reg;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (a_ready && in_valid)
        begin
            a_word_reg <= word;
            a_tail_reg <= tail_bytes;
            a_last_reg <= last;
        end
        if (b_ready && a_done)
        begin
            b_hash_reg <= tail_hash;
            b_len_reg  <= tail_len;
        end
        if (c_ready && b_valid_reg)
        begin
            c_hash_reg <= aval_front(b_hash_reg);
            c_len_reg  <= b_len_reg;
        end
        if (d_ready && c_valid_reg)
        begin
            d_hash_reg <= aval_back(c_hash_reg);
            d_len_reg  <= c_len_reg;
        end
    end

    assign hash_value  = d_hash_reg;
    assign byte_length = d_len_reg;
    assign out_valid   = d_valid_reg;

endmodule
`default_nettype wire

/* rtl/shsf_checker.sv */
// Port-level checker for the SuperFastHash core, bound to the core module.
`default_nettype none
module shsf_checker
    import shsf_pkg::*;
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               in_stall,
    input wire logic [WordW-1:0]   hash_value,
    input wire logic [WordW-1:0]   byte_length,
    input wire logic               out_valid,
    input wire logic               out_stall
);

    // a stalled result stays up
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("out_valid dropped while stalled");

    // a stalled result keeps its payload
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(hash_value) && $stable(byte_length))
        else $error("result changed while stalled");

    // empty string hashes to zero
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (byte_length == '0) |-> (hash_value == '0))
        else $error("empty string gave nonzero hash");

    // the result slot only empties through a taken beat
    a_out_drain: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(out_valid) |-> $past(!out_stall))
        else $error("result dropped without handshake");

    // input side stalls only while the output side is backed up
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled with a free output");

endmodule

bind string_hash_superfast_core shsf_checker u_shsf_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_stall    (in_stall),
    .hash_value  (hash_value),
    .byte_length (byte_length),
    .out_valid   (out_valid),
    .out_stall   (out_stall)
);
`default_nettype wire

/* sim/tb.sv */
// Testbench for string_hash_superfast_core: random strings against a scoreboard.
`timescale 1ns / 1ps

module tb;
    import shsf_pkg::*;

    localparam int TotalBeats = 1065;
    localparam int QuietLimit = 1000;
    localparam int DrainCycles = 20;
    localparam int PressureAt = 200;
    localparam int PressureCycles = 80;

    typedef struct {
        word_t hash;
        word_t len;
    } hash_result_t;

    class hash_scoreboard;
        word_t        run_hash;
        word_t        run_count;
        hash_result_t pending_q[$];
        int           errors;
        int           beats;

        function new();
            run_hash  = '0;
            run_count = '0;
            errors    = 0;
            beats     = 0;
        endfunction

        function word_t count_add(word_t a, word_t b);
            logic [WordW:0] s;
            s = {1'b0, a} + {1'b0, b};
            return s[WordW] ? CountMax : s[WordW-1:0];
        endfunction

        function word_t round_group(word_t h, word_t w);
            word_t hi;
            hi = {16'd0, w[31:16]};
            h = h + {16'd0, w[15:0]};
            h = (h << 16) ^ ((hi << 11) ^ h);
            h = h + (h >> 11);
            return h;
        endfunction

        function word_t fold_tail(word_t h, word_t w, tail_t n);
            case (tail_code_t'(n))
                TAIL_THREE:
                begin
                    h = h + {16'd0, w[15:0]};
                    h = h ^ (h << 16);
                    h = h ^ (word_t'(w[23:16]) << 18);
                    h = h + (h >> 11);
                end
                TAIL_TWO:
                begin
                    h = h + {16'd0, w[15:0]};
                    h = h ^ (h << 11);
                    h = h + (h >> 17);
                end
                TAIL_ONE:
                begin
                    h = h + {24'd0, w[7:0]};
                    h = h ^ (h << 10);
                    h = h + (h >> 1);
                end
                default:
                begin
                end
            endcase
            return h;
        endfunction

        function word_t scramble(word_t h);
            h = h ^ (h << 3);
            h = h + (h >> 5);
            h = h ^ (h << 4);
            h = h + (h >> 17);
            h = h ^ (h << 25);
            h = h + (h >> 6);
            return h;
        endfunction

        // Accepted input beat: advance running state, queue a result on last.
        function void take_beat(word_t w, tail_t n, logic is_last);
            hash_result_t r;
            beats++;
            if (!is_last)
            begin
                run_hash  = round_group(run_hash, w);
                run_count = count_add(run_count, 32'd4);
            end
            else
            begin
                r.hash = scramble(fold_tail(run_hash, w, n));
                r.len  = count_add(run_count, {30'd0, n});
                pending_q.push_back(r);
                run_hash  = '0;
                run_count = '0;
            end
        endfunction

        task report(string msg);
            errors++;
            if (errors <= 40)
                $display("MISMATCH @%0t: %s", $time, msg);
        endtask

        task check_result(word_t h, word_t len);
            hash_result_t e;
            if (pending_q.size() == 0)
            begin
                report($sformatf("unexpected result hash %h len %0d", h, len));
                return;
            end
            e = pending_q.pop_front();
            if (h !== e.hash)
                report($sformatf("hash_value %h, want %h", h, e.hash));
            if (len !== e.len)
                report($sformatf("byte_length %0d, want %0d", len, e.len));
        endtask

        function int pending();
            return pending_q.size();
        endfunction
    endclass

    logic  clk = 1'b0;
    logic  rst_n = 1'b0;
    word_t word = '0;
    tail_t tail_bytes = '0;
    logic  last = 1'b0;
    logic  in_valid = 1'b0;
    logic  in_stall;
    word_t hash_value;
    word_t byte_length;
    logic  out_valid;
    logic  out_stall = 1'b0;

    hash_scoreboard sb = new();

    string_hash_superfast_core u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .word        (word),
        .tail_bytes  (tail_bytes),
        .last        (last),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .hash_value  (hash_value),
        .byte_length (byte_length),
        .out_valid   (out_valid),
        .out_stall   (out_stall)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic int pick_gap(input bit busy);
        int r;
        if (!busy)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic send_beat(input word_t w, input tail_t n, input logic l, input bit busy);
        int gap;
        gap = pick_gap(busy);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        word       <= w;
        tail_bytes <= n;
        last       <= l;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        sb.take_beat(w, n, l);
    endtask

    // Full groups with random content (tail_bytes is noise there), then a random tail.
    task automatic send_string(input int groups, input bit busy);
        word_t w;
        int    g;
        for (g = 0; g < groups; g++)
        begin
            case ($urandom_range(0, 15))
                0: w = '0;
                1: w = '1;
                default: w = $urandom;
            endcase
            send_beat(w, tail_t'($urandom_range(0, 3)), 1'b0, busy);
        end
        send_beat($urandom, tail_t'($urandom_range(0, 3)), 1'b1, busy);
    endtask

    // Result side: check accepted beats, drive random stall, one long hold-off.
    initial
    begin : result_side
        int r;
        int hold_left;
        int phase_left;
        bit recv_busy;
        bit hold_done;
        hold_left  = 0;
        phase_left = 0;
        recv_busy  = 1'b0;
        hold_done  = 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid === 1'b1 && out_stall == 1'b0)
                sb.check_result(hash_value, byte_length);
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (!hold_done && sb.beats >= PressureAt)
            begin
                hold_done = 1'b1;
                hold_left = PressureCycles - 1;
                out_stall <= 1'b1;
            end
            else
            begin
                if (phase_left == 0)
                begin
                    recv_busy  = ($urandom_range(0, 2) != 0);
                    phase_left = $urandom_range(20, 120);
                end
                phase_left--;
                r = $urandom_range(0, 99);
                if (!recv_busy || r < 70)
                    out_stall <= 1'b0;
                else
                begin
                    hold_left = (r < 97) ? $urandom_range(0, 2) : $urandom_range(8, 30);
                    out_stall <= 1'b1;
                end
            end
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if ((in_valid === 1'b1 && in_stall === 1'b0) ||
                (out_valid === 1'b1 && out_stall === 1'b0))
                quiet = 0;
            else
                quiet++;
            if (quiet >= QuietLimit)
            begin
                $display("tb: errors");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        int r;
        int groups;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty string, then each tail count with the unused bytes set
        send_beat(32'hFFFF_FFFF, TAIL_NONE, 1'b1, 1'b0);
        send_beat(32'hFFFF_FFFF, TAIL_ONE, 1'b1, 1'b0);
        send_beat(32'hFFFF_FFFF, TAIL_TWO, 1'b1, 1'b0);
        send_beat(32'hFFFF_FFFF, TAIL_THREE, 1'b1, 1'b0);
        send_beat(32'h0000_0000, TAIL_THREE, 1'b1, 1'b0);
        send_beat(32'hFFFF_0000, TAIL_TWO, 1'b1, 1'b0);
        // groups with tail_bytes set, which must be ignored
        send_beat(32'hFFFF_FFFF, TAIL_THREE, 1'b0, 1'b0);
        send_beat(32'h0000_0000, TAIL_NONE, 1'b1, 1'b0);
        send_beat(32'h0000_0000, TAIL_ONE, 1'b0, 1'b0);
        send_beat(32'hFFFF_FFFF, TAIL_TWO, 1'b0, 1'b0);
        send_beat(32'hFFFF_FF80, TAIL_ONE, 1'b1, 1'b0);
        send_beat(32'h8000_0001, TAIL_NONE, 1'b0, 1'b0);
        send_beat(32'h7F7F_7F7F, TAIL_NONE, 1'b0, 1'b0);
        send_beat(32'hA5A5_5A5A, TAIL_NONE, 1'b0, 1'b0);
        send_beat(32'hAB80_FF7F, TAIL_THREE, 1'b1, 1'b0);

        while (sb.beats < TotalBeats)
        begin
            r = $urandom_range(0, 99);
            if (r < 75)
                groups = $urandom_range(0, 6);
            else if (r < 97)
                groups = $urandom_range(7, 24);
            else
                groups = $urandom_range(25, 80);
            send_string(groups, $urandom_range(0, 3) != 0);
        end
        in_valid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);

        if (sb.errors == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule

/* filelist.f */
rtl/shsf_pkg.sv
rtl/string_hash_superfast_core.sv
rtl/shsf_checker.sv
sim/tb.sv
